// ===== rtl/core/gwm_pkg.sv =====
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types and constants for the glob wildcard matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

  localparam int unsigned SymW              = 8;
  localparam int unsigned MaxPatternDefault = 64;

  localparam logic [SymW-1:0] SymAnyOne = 8'h3F;  // '?'
  localparam logic [SymW-1:0] SymAnyRun = 8'h2A;  // '*'

  typedef enum logic [1:0] {
    ActClear  = 2'd0,
    ActAppend = 2'd1,
    ActValue  = 2'd2,
    ActEnd    = 2'd3
  } action_e;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic            clr;      // drop stored pattern
    logic            restart;  // back to position zero only
    logic            step;     // advance on a value byte
    logic [SymW-1:0] sym;      // value byte or pattern byte
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/glob_wildcard_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_unit
// Whole-string glob matcher ('*' any run, '?' any byte) on a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis group; tuser carries the action (clear
//   pattern, append pattern byte, value byte, end of value) and tdata the
//   byte. Load a pattern with clear then appends, stream value bytes, then
//   send end of value. Only end of value gives a response on m_axis:
//   tdata[0] is the match bit, tuser the pattern overflow flag (match is
//   then 0). The pattern stays loaded for the next value.
//   One request per cycle is taken unless stalled; a response appears in the
//   cycle after its end-of-value request. The per-cycle limit is the
//   star-closure prefix network feeding the cell row (clog2(MAX_PATTERN+1)
//   levels). A single output register holds the response; while it is full
//   and m_axis_tready_i is low, s_axis_tready_o is low.
//   Reset leaves an empty pattern, no overflow and an empty output.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_wildcard_matcher_unit #(
  parameter int unsigned MAX_PATTERN = gwm_pkg::MaxPatternDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] symbol
  input  wire logic [1:0] s_axis_tuser_i,   // [1:0] action
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [0] matched, [7:1] zero
  output logic            m_axis_tuser_o    // [0] pattern_overflow
);

  localparam int unsigned NumPos = MAX_PATTERN + 1;
  localparam int unsigned LenW   = $clog2(NumPos);

  gwm_pkg::action_e    act;
  gwm_pkg::cell_ctrl_t ctrl;
  logic                req_hs;
  logic                full;
  logic                do_end;

  logic [LenW-1:0]        len_q, len_d;
  logic                   ovf_q, ovf_d;
  logic                   last_q, last_d;
  logic                   m_valid_q;
  logic                   matched_q;
  logic                   m_ovf_q;

  logic [MAX_PATTERN-1:0] wr_en;
  logic [MAX_PATTERN-1:0] star;
  logic [MAX_PATTERN-1:0] cell_act;
  logic [MAX_PATTERN:0]   carry;
  logic [NumPos-1:0]      active;
  logic [NumPos-1:0]      prop;
  logic [NumPos-1:0]      closed;

  assign act             = gwm_pkg::action_e'(s_axis_tuser_i);
  assign s_axis_tready_o = ~m_valid_q | m_axis_tready_i;
  assign req_hs          = s_axis_tvalid_i & s_axis_tready_o;
  assign full            = (len_q == LenW'(MAX_PATTERN));

  always_comb begin
    ctrl     = '0;
    ctrl.sym = s_axis_tdata_i;
    do_end   = 1'b0;
    if (req_hs) begin
      case (act)
        gwm_pkg::ActClear: begin
          ctrl.clr     = 1'b1;
          ctrl.restart = 1'b1;
        end
        gwm_pkg::ActAppend: begin
          ctrl.restart = 1'b1;
        end
        gwm_pkg::ActValue: begin
          ctrl.step = 1'b1;
        end
        gwm_pkg::ActEnd: begin
          ctrl.restart = 1'b1;
          do_end       = 1'b1;
        end
        default: begin
          ctrl.restart = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    for (int unsigned i = 0; i < MAX_PATTERN; i++) begin
      wr_en[i] = req_hs & (act == gwm_pkg::ActAppend) & (len_q == LenW'(i));
    end
  end

  assign carry[0] = 1'b0;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    gwm_cell #(
      .First (i == 0)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .wr_en_i  (wr_en[i]),
      .closed_i (closed[i]),
      .carry_i  (carry[i]),
      .star_o   (star[i]),
      .carry_o  (carry[i+1]),
      .active_o (cell_act[i])
    );
  end

  assign active = {last_q, cell_act};
  assign prop   = {star, 1'b0};

  gwm_closure #(
    .NumPos (NumPos)
  ) u_closure (
    .active_i (active),
    .prop_i   (prop),
    .closed_o (closed)
  );

  always_comb begin
    len_d  = len_q;
    ovf_d  = ovf_q;
    last_d = last_q;
    if (ctrl.clr) begin
      len_d = '0;
      ovf_d = 1'b0;
    end else if (req_hs && act == gwm_pkg::ActAppend) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        len_d = len_q + LenW'(1);
      end
    end
    if (ctrl.restart) begin
      last_d = 1'b0;
    end else if (ctrl.step) begin
      last_d = carry[MAX_PATTERN];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      ovf_q     <= 1'b0;
      last_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      last_q <= last_d;
      if (do_end) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_end) begin
      matched_q <= ~ovf_q & closed[len_q];
      m_ovf_q   <= ovf_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'd0, matched_q};
  assign m_axis_tuser_o  = m_ovf_q;

  // a response only follows an accepted end-of-value request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(req_hs && act == gwm_pkg::ActEnd))
    else $error("response without end-of-value request");

  // overflow forces no match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_ovf_q |-> !matched_q)
    else $error("match reported with pattern overflow");

  // stored length never exceeds the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MAX_PATTERN))
    else $error("pattern length beyond store");

  // clear empties the pattern and drops overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_hs && act == gwm_pkg::ActClear |=> len_q == '0 && !ovf_q)
    else $error("clear did not empty pattern");

  // overflow only once the store is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("overflow with room left");

endmodule

`default_nettype wire

// ===== rtl/core/gwm_cell.sv =====
// ----------------------------------------------------------------------------
// gwm_cell
// One pattern position: stored byte, fill bit and active bit.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_cell #(
  parameter bit First = 1'b0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire gwm_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic                 wr_en_i,
  input  wire logic                 closed_i,
  input  wire logic                 carry_i,
  output logic                      star_o,
  output logic                      carry_o,
  output logic                      active_o
);

  logic [gwm_pkg::SymW-1:0] sym_q;
  logic                     valid_q, valid_d;
  logic                     active_q, active_d;
  logic                     hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      sym_q <= ctrl_i.sym;
    end
  end

  assign star_o  = valid_q & (sym_q == gwm_pkg::SymAnyRun);
  assign hit     = (sym_q == gwm_pkg::SymAnyOne) | (sym_q == ctrl_i.sym);
  assign carry_o = closed_i & valid_q & ~star_o & hit;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end else if (wr_en_i) begin
      valid_d = 1'b1;
    end
  end

  always_comb begin
    active_d = active_q;
    if (ctrl_i.restart) begin
      active_d = First;
    end else if (ctrl_i.step) begin
      active_d = (closed_i & star_o) | carry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      active_q <= First;
    end else begin
      valid_q  <= valid_d;
      active_q <= active_d;
    end
  end

  assign active_o = active_q;

endmodule

`default_nettype wire

// ===== rtl/core/gwm_closure.sv =====
// ----------------------------------------------------------------------------
// gwm_closure
// Parallel-prefix closure of the active set over star positions.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_closure #(
  parameter int unsigned NumPos = 65
) (
  input  wire logic [NumPos-1:0] active_i,
  input  wire logic [NumPos-1:0] prop_i,    // prop[j]: position j-1 is a star
  output logic      [NumPos-1:0] closed_o
);

  localparam int unsigned Levels = $clog2(NumPos);

  always_comb begin
    logic [NumPos-1:0] g;
    logic [NumPos-1:0] p;
    g = active_i;
    p = prop_i;
    for (int unsigned l = 0; l < Levels; l++) begin
      g = g | (p & (g << (1 << l)));
      p = p & (p << (1 << l));
    end
    closed_o = g;
  end

endmodule

`default_nettype wire
